/* rtl/core/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions for the linear interpolation resampler
// Widths, register map, reset values and the command and status types that
// join the controller, the datapath and the divider.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int RATE_W    = 18;
	localparam int LEN_W     = 24;
	localparam int IDX_W     = 40;
	localparam int PROD_W    = LEN_W + RATE_W;
	localparam int FRAC_W    = 16;
	localparam int QUO_W     = IDX_W + RATE_W;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);
	localparam int MAX_BURST = 64;
	localparam int CNT_W     = $clog2(MAX_BURST + 1);
	localparam int IPROD_W   = 2 * (SAMPLE_W + 1);
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [RATE_W-1:0] SRC_RATE_RST = RATE_W'(11025);
	localparam logic [RATE_W-1:0] TGT_RATE_RST = RATE_W'(44100);
	localparam logic [LEN_W-1:0]  SRC_LEN_RST  = LEN_W'(1);
	localparam logic [IDX_W-1:0]  TOTAL_MAX    = '1;

	localparam logic [1:0] REG_SRC_RATE = 2'd0;
	localparam logic [1:0] REG_TGT_RATE = 2'd1;
	localparam logic [1:0] REG_SRC_LEN  = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_LOAD,
		OP_MUL_TOT,
		OP_MUL_END,
		OP_END_TOTAL,
		OP_AVAIL,
		OP_MUL_QLO,
		OP_MUL_QHI,
		OP_MUL_INTERP,
		OP_EMIT,
		OP_PASS,
		OP_FINISH,
		OP_DIV_TOT,
		OP_DIV_END,
		OP_DIV_Q,
		OP_DIV_R,
		OP_DIV_F
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic             first;
		logic             eq;
		logic             last;
		logic             has_work;
		logic             cnt_one;
		logic             out_free;
		logic             div_busy;
		logic             div_done;
		logic [CNT_W-1:0] cnt;
	} dp_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/core/lir_div.sv */
// ----------------------------------------------------------------------------
// lir_div: iterative restoring divider
// Produces one quotient bit per cycle from a left-aligned dividend. The
// remainder may be preloaded so that a division can be continued into
// fractional bits.
// ----------------------------------------------------------------------------
module lir_div import lir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [QUO_W-1:0]     dividend,
	input  logic [RATE_W-1:0]    divisor,
	input  logic [RATE_W-1:0]    rem_init,
	input  logic [DIV_CNT_W-1:0] count,
	output div_stat_t            stat,
	output logic [QUO_W-1:0]     quot,
	output logic [RATE_W-1:0]    rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [QUO_W-1:0]     shreg_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W-1:0]    dvsr_q;
	logic [RATE_W:0]      trial;
	logic [RATE_W:0]      diff;
	logic                 ge;

	assign trial = {rem_q, shreg_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, dvsr_q};
	assign diff  = trial - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			rem_q   <= rem_init;
			dvsr_q  <= divisor;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[QUO_W-2:0], ge};
			rem_q   <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = shreg_q;
	assign rem       = rem_q;

endmodule

/* rtl/core/lir_datapath.sv */
// ----------------------------------------------------------------------------
// lir_datapath: arithmetic and state of the resampler
// Holds the clip state, the shared multiplier, the divider and the output
// register, and carries out one command from the controller per cycle.
// ----------------------------------------------------------------------------
module lir_datapath import lir_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [RATE_W-1:0]   source_rate,
	input  logic [RATE_W-1:0]   dest_rate,
	input  logic [LEN_W-1:0]    source_length,
	input  logic [SAMPLE_W-1:0] sample_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                final_res,
	output logic                dropped
);

	logic [RATE_W-1:0]    rin_e;
	logic [RATE_W-1:0]    rout_e;
	logic [LEN_W-1:0]     len_e;
	logic [LEN_W-1:0]     len_m1;

	logic [SAMPLE_W-1:0]  cur_q;
	logic [SAMPLE_W-1:0]  prior_q;
	logic [LEN_W-1:0]     kin_q;
	logic [IDX_W-1:0]     oi_q;
	logic [IDX_W-1:0]     total_q;
	logic                 last_q;
	logic                 eq_q;
	logic [PROD_W-1:0]    mul_q;
	logic [IDX_W-1:0]     end_q;
	logic [IDX_W-1:0]     new_oi_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 drop_q;
	logic                 fin_q;
	logic [QUO_W-1:0]     qacc_q;
	logic [QUO_W-1:0]     idx_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W-1:0]    step_a_q;
	logic [RATE_W-1:0]    step_b_q;
	logic [FRAC_W-1:0]    frac_q;
	logic signed [IPROD_W-1:0] iprod_q;
	dp_op_t               div_kind_q;

	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_data_q;
	logic                 out_last_q;
	logic                 out_drop_q;

	logic [LEN_W-1:0]     mul_a;
	logic [RATE_W-1:0]    mul_b;
	logic [PROD_W-1:0]    mul_res;

	logic                 div_start;
	logic [QUO_W-1:0]     div_dividend;
	logic [RATE_W-1:0]    div_divisor;
	logic [RATE_W-1:0]    div_rem_init;
	logic [DIV_CNT_W-1:0] div_count;
	div_stat_t            div_stat;
	logic [QUO_W-1:0]     div_quot;
	logic [RATE_W-1:0]    div_rem;
	logic [PROD_W:0]      ceil_num;

	logic [IDX_W-1:0]     avail;
	logic                 has_work;
	logic [IDX_W-1:0]     new_oi;
	logic [QUO_W-1:0]     last_idx;
	logic [RATE_W:0]      rem_sum;
	logic [RATE_W:0]      rem_wrap;
	logic                 wrap;
	logic signed [SAMPLE_W:0] sdiff;
	logic [SAMPLE_W+1:0]  ival;
	logic [SAMPLE_W-1:0]  emit_val;
	logic [LEN_W:0]       kin_inc;
	logic                 load_out;

	assign rin_e  = (source_rate == '0) ? RATE_W'(1) : source_rate;
	assign rout_e = (dest_rate == '0) ? RATE_W'(1) : dest_rate;
	assign len_e  = (source_length == '0) ? LEN_W'(1) : source_length;
	assign len_m1 = len_e - LEN_W'(1);

	// Shared unsigned multiplier.
	always_comb begin
		unique case (cmd.op)
			OP_MUL_TOT: begin
				mul_a = len_e;
				mul_b = rout_e;
			end
			OP_MUL_END: begin
				mul_a = kin_q;
				mul_b = rout_e;
			end
			OP_MUL_QLO: begin
				mul_a = oi_q[LEN_W-1:0];
				mul_b = rin_e;
			end
			OP_MUL_QHI: begin
				mul_a = LEN_W'(oi_q[IDX_W-1:LEN_W]);
				mul_b = rin_e;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_res  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign ceil_num = {1'b0, mul_q} + (PROD_W + 1)'(rin_e) - (PROD_W + 1)'(1);

	always_comb begin
		div_start    = 1'b1;
		div_rem_init = '0;
		div_divisor  = rout_e;
		unique case (cmd.op)
			OP_DIV_TOT: begin
				div_dividend = {mul_q, (QUO_W - PROD_W)'(0)};
				div_count    = DIV_CNT_W'(PROD_W);
				div_divisor  = rin_e;
			end
			OP_DIV_END: begin
				div_dividend = {ceil_num, (QUO_W - PROD_W - 1)'(0)};
				div_count    = DIV_CNT_W'(PROD_W + 1);
				div_divisor  = rin_e;
			end
			OP_DIV_Q: begin
				div_dividend = qacc_q;
				div_count    = DIV_CNT_W'(QUO_W);
			end
			OP_DIV_R: begin
				div_dividend = {rin_e, IDX_W'(0)};
				div_count    = DIV_CNT_W'(RATE_W);
			end
			OP_DIV_F: begin
				div_dividend = '0;
				div_count    = DIV_CNT_W'(FRAC_W);
				div_rem_init = rem_q;
			end
			default: begin
				div_start    = 1'b0;
				div_dividend = '0;
				div_count    = '0;
			end
		endcase
	end

	lir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rem_init (div_rem_init),
		.count    (div_count),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign has_work = end_q > oi_q;
	assign avail    = end_q - oi_q;
	assign new_oi   = has_work ? end_q : oi_q;
	assign last_idx = QUO_W'(len_m1);
	assign rem_sum  = {1'b0, rem_q} + {1'b0, step_b_q};
	assign wrap     = rem_sum >= {1'b0, rout_e};
	assign rem_wrap = rem_sum - {1'b0, rout_e};
	assign sdiff    = $signed({cur_q[SAMPLE_W-1], cur_q}) - $signed({prior_q[SAMPLE_W-1], prior_q});
	assign ival     = {{2{prior_q[SAMPLE_W-1]}}, prior_q} + iprod_q[IPROD_W-1:FRAC_W];
	assign emit_val = (idx_q >= last_idx) ? cur_q : ival[SAMPLE_W-1:0];
	assign kin_inc  = {1'b0, kin_q} + (LEN_W + 1)'(1);
	assign load_out = (cmd.op == OP_EMIT) || (cmd.op == OP_PASS);

	// Clip state and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q    <= '0;
			kin_q      <= '0;
			oi_q       <= '0;
			total_q    <= '0;
			last_q     <= 1'b0;
			eq_q       <= 1'b0;
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			fin_q      <= 1'b0;
			div_kind_q <= OP_NOP;
		end else begin
			if (div_start) begin
				div_kind_q <= cmd.op;
			end
			if (div_stat.done && div_kind_q == OP_DIV_TOT) begin
				if (div_quot > QUO_W'(TOTAL_MAX)) begin
					total_q <= TOTAL_MAX;
				end else if (div_quot == '0) begin
					total_q <= IDX_W'(1);
				end else begin
					total_q <= div_quot[IDX_W-1:0];
				end
			end
			unique case (cmd.op)
				OP_LOAD: begin
					last_q <= kin_q >= len_m1;
					eq_q   <= rin_e == rout_e;
					if (kin_q == '0) begin
						total_q <= IDX_W'(len_e);
					end
				end
				OP_AVAIL: begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
					if (has_work) begin
						if (avail > IDX_W'(MAX_BURST)) begin
							cnt_q  <= CNT_W'(MAX_BURST);
							drop_q <= 1'b1;
						end else begin
							cnt_q <= avail[CNT_W-1:0];
						end
					end
					fin_q <= new_oi >= total_q;
				end
				OP_EMIT: begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_FINISH: begin
					prior_q <= cur_q;
					if (last_q) begin
						kin_q <= '0;
						oi_q  <= '0;
					end else begin
						kin_q <= kin_inc[LEN_W-1:0];
						oi_q  <= eq_q ? IDX_W'(kin_inc) : new_oi_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (div_stat.done) begin
			unique case (div_kind_q)
				OP_DIV_END: begin
					end_q <= (div_quot >= QUO_W'(total_q)) ? total_q : div_quot[IDX_W-1:0];
				end
				OP_DIV_Q: begin
					idx_q <= div_quot;
					rem_q <= div_rem;
				end
				OP_DIV_R: begin
					step_a_q <= div_quot[RATE_W-1:0];
					step_b_q <= div_rem;
				end
				OP_DIV_F: begin
					frac_q <= div_quot[FRAC_W-1:0];
				end
				default: begin
				end
			endcase
		end
		unique case (cmd.op)
			OP_CAPTURE: begin
				cur_q <= sample_in;
			end
			OP_MUL_TOT, OP_MUL_END, OP_MUL_QLO: begin
				mul_q <= mul_res;
			end
			OP_MUL_QHI: begin
				qacc_q <= QUO_W'(mul_q) + {mul_res[QUO_W-LEN_W-1:0], LEN_W'(0)};
			end
			OP_END_TOTAL: begin
				end_q <= total_q;
			end
			OP_AVAIL: begin
				new_oi_q <= new_oi;
			end
			OP_MUL_INTERP: begin
				iprod_q <= sdiff * $signed({1'b0, frac_q});
			end
			OP_EMIT: begin
				idx_q <= idx_q + QUO_W'(step_a_q) + QUO_W'(wrap);
				rem_q <= wrap ? rem_wrap[RATE_W-1:0] : rem_sum[RATE_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_data_q <= emit_val;
			out_last_q <= (cnt_q == CNT_W'(1)) && fin_q;
			out_drop_q <= drop_q;
		end else if (cmd.op == OP_PASS) begin
			out_data_q <= cur_q;
			out_last_q <= last_q;
			out_drop_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;
	assign final_res  = out_last_q;
	assign dropped    = out_drop_q;

	assign stat.first    = kin_q == '0;
	assign stat.eq       = rin_e == rout_e;
	assign stat.last     = last_q;
	assign stat.has_work = has_work;
	assign stat.cnt_one  = cnt_q == CNT_W'(1);
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.div_busy = div_stat.busy;
	assign stat.div_done = div_stat.done;
	assign stat.cnt      = cnt_q;

endmodule

/* rtl/core/lir_ctrl.sv */
// ----------------------------------------------------------------------------
// lir_ctrl: sequencing state machine of the resampler
// Steps the datapath through the output count, the emission bound, the
// position set-up and one interpolation per output; equal rates pass through.
// ----------------------------------------------------------------------------
module lir_ctrl import lir_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		ST_IDLE     = 17'h00001,
		ST_LOAD     = 17'h00002,
		ST_TOT_MUL  = 17'h00004,
		ST_TOT_DIV  = 17'h00008,
		ST_END_SEL  = 17'h00010,
		ST_END_DIV  = 17'h00020,
		ST_AVAIL    = 17'h00040,
		ST_Q_LO     = 17'h00080,
		ST_Q_HI     = 17'h00100,
		ST_Q_DIV    = 17'h00200,
		ST_R_DIV    = 17'h00400,
		ST_F_DIV    = 17'h00800,
		ST_DIV_WAIT = 17'h01000,
		ST_I_MUL    = 17'h02000,
		ST_EMIT     = 17'h04000,
		ST_PASS     = 17'h08000,
		ST_FINISH   = 17'h10000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t ret_q;
	state_t ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd.op   = OP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.op = OP_LOAD;
				if (stat.eq) begin
					state_d = ST_PASS;
				end else if (stat.first) begin
					state_d = ST_TOT_MUL;
				end else begin
					state_d = ST_END_SEL;
				end
			end
			ST_TOT_MUL: begin
				cmd.op  = OP_MUL_TOT;
				state_d = ST_TOT_DIV;
			end
			ST_TOT_DIV: begin
				cmd.op  = OP_DIV_TOT;
				ret_d   = ST_END_SEL;
				state_d = ST_DIV_WAIT;
			end
			ST_END_SEL: begin
				if (stat.last) begin
					cmd.op  = OP_END_TOTAL;
					state_d = ST_AVAIL;
				end else begin
					cmd.op  = OP_MUL_END;
					state_d = ST_END_DIV;
				end
			end
			ST_END_DIV: begin
				cmd.op  = OP_DIV_END;
				ret_d   = ST_AVAIL;
				state_d = ST_DIV_WAIT;
			end
			ST_AVAIL: begin
				cmd.op  = OP_AVAIL;
				state_d = stat.has_work ? ST_Q_LO : ST_FINISH;
			end
			ST_Q_LO: begin
				cmd.op  = OP_MUL_QLO;
				state_d = ST_Q_HI;
			end
			ST_Q_HI: begin
				cmd.op  = OP_MUL_QHI;
				state_d = ST_Q_DIV;
			end
			ST_Q_DIV: begin
				cmd.op  = OP_DIV_Q;
				ret_d   = ST_R_DIV;
				state_d = ST_DIV_WAIT;
			end
			ST_R_DIV: begin
				cmd.op  = OP_DIV_R;
				ret_d   = ST_F_DIV;
				state_d = ST_DIV_WAIT;
			end
			ST_F_DIV: begin
				cmd.op  = OP_DIV_F;
				ret_d   = ST_I_MUL;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = ret_q;
				end
			end
			ST_I_MUL: begin
				cmd.op  = OP_MUL_INTERP;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = stat.cnt_one ? ST_FINISH : ST_F_DIV;
				end
			end
			ST_PASS: begin
				if (stat.out_free) begin
					cmd.op  = OP_PASS;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.op  = OP_FINISH;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/linear_interp_resampler.sv */
// With equal rates a sample is captured, compared and passed to the output register.
// Otherwise a sample runs the emission bound division (the total copied on the last sample),
// plus the output count division on a clip's first sample, plus the position set-up and one
// interpolation per output. One item is taken at a time; emission waits for a free output.
// Reset is asynchronous and active low: clip state clears, registers take defaults.
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Resamples a mono clip of signed 16-bit samples between two rates, emitting
// each output as soon as both neighbouring source samples have arrived.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,  // [15:0] sample_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,  // [15:0] sample_out
	output logic              m_tlast,
	output logic [0:0]        m_tuser   // [0] dropped
);

	logic [RATE_W-1:0] source_rate_q;
	logic [RATE_W-1:0] dest_rate_q;
	logic [LEN_W-1:0]  source_length_q;
	logic              wr_en;
	dp_cmd_t           dp_cmd;
	dp_stat_t          dp_stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rate_q   <= SRC_RATE_RST;
			dest_rate_q     <= TGT_RATE_RST;
			source_length_q <= SRC_LEN_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SRC_RATE: source_rate_q   <= pwdata[RATE_W-1:0];
				REG_TGT_RATE: dest_rate_q     <= pwdata[RATE_W-1:0];
				REG_SRC_LEN:  source_length_q <= pwdata[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SRC_RATE: prdata = DATA_W'(source_rate_q);
			REG_TGT_RATE: prdata = DATA_W'(dest_rate_q);
			REG_SRC_LEN:  prdata = DATA_W'(source_length_q);
			default:      prdata = '0;
		endcase
	end

	lir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	lir_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.source_rate   (source_rate_q),
		.dest_rate     (dest_rate_q),
		.source_length (source_length_q),
		.sample_in     (s_tdata),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.sample_out    (m_tdata),
		.final_res     (m_tlast),
		.dropped       (m_tuser[0])
	);

`ifndef SYNTHESIS
	a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !dp_stat.div_busy)
		else $error("Input transaction taken while the divider is busy.");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("Input still ready in the cycle after a transaction.");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.cnt <= CNT_W'(MAX_BURST))
		else $error("Output count exceeds the burst limit.");
`endif

endmodule
